// ----- sv/cct_pkg.sv -----
// ----------------------------------------------------------------------------
// cct_pkg
// Shared types and constants of the character class tokenizer: scan modes,
// character class flags, the result record of one step and special codes.
// ----------------------------------------------------------------------------
package cct_pkg;

   typedef enum logic [2:0] {
      MODE_IDLE   = 3'd0,
      MODE_WORD   = 3'd1,
      MODE_OPER   = 3'd2,
      MODE_SEPA   = 3'd3,
      MODE_BRKT   = 3'd4,
      MODE_TEXT   = 3'd5,
      MODE_REMARK = 3'd6
   } mode_type;

   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;

   typedef struct packed {
      logic is_space;
      logic is_word;
      logic is_oper;
      logic is_sepa;
      logic is_brkt;
      logic is_hash;
      logic is_quote;
      logic is_bslash;
      logic is_nl;
   } char_class_type;

   typedef struct packed {
      logic     append;
      logic     ends_before;
      logic     ends_after;
      logic [2:0] closed_class;
      mode_type open_class;
      logic     escape;
      logic     bad_char;
   } step_result_type;

endpackage

// ----- sv/cct_classify.sv -----
// ----------------------------------------------------------------------------
// cct_classify
// Decodes one character byte into its lexical class flags.
// ----------------------------------------------------------------------------
module cct_classify (
   input  logic [7:0]              ch,
   output cct_pkg::char_class_type flags
);
   import cct_pkg::*;

   always_comb begin
      flags = '0;
      flags.is_space  = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_NL);
      flags.is_hash   = (ch == CH_HASH);
      flags.is_quote  = (ch == CH_QUOTE);
      flags.is_bslash = (ch == CH_BSLASH);
      flags.is_nl     = (ch == CH_NL);

      case (ch) inside
         [8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39],
         8'h2E, 8'h21, 8'h5F, 8'h5B, 8'h5D,
         8'h3F, 8'h2D, 8'h3C, 8'h3E, 8'h3D: flags.is_word = 1'b1;
         default:                           flags.is_word = 1'b0;
      endcase

      case (ch) inside
         8'h7E, 8'h2B, 8'h2D, 8'h2A, 8'h25, 8'h2F,
         8'h3D, 8'h26, 8'h7C, 8'h3C, 8'h3E, 8'h21: flags.is_oper = 1'b1;
         default:                                  flags.is_oper = 1'b0;
      endcase

      case (ch) inside
         8'h3A, 8'h2C, 8'h3B: flags.is_sepa = 1'b1;
         default:             flags.is_sepa = 1'b0;
      endcase

      case (ch) inside
         8'h28, 8'h29, 8'h7B, 8'h7D: flags.is_brkt = 1'b1;
         default:                    flags.is_brkt = 1'b0;
      endcase
   end

endmodule

// ----- sv/cct_step.sv -----
// ----------------------------------------------------------------------------
// cct_step
// Next mode and token marks for one character, given the current mode,
// the pending escape flag and the character's class flags.
// ----------------------------------------------------------------------------
module cct_step (
   input  cct_pkg::mode_type        mode,
   input  logic                     escape,
   input  cct_pkg::char_class_type  flags,
   output cct_pkg::step_result_type res
);
   import cct_pkg::*;

   logic member;
   logic rescan;

   always_comb begin
      res              = '0;
      res.open_class   = MODE_IDLE;
      res.closed_class = MODE_IDLE;
      member           = 1'b0;
      rescan           = 1'b0;

      unique case (mode)
         MODE_TEXT: begin
            res.open_class = MODE_TEXT;
            if (escape) begin
               res.append = 1'b1;
            end else if (flags.is_bslash) begin
               res.escape = 1'b1;
            end else if (flags.is_quote) begin
               res.append       = 1'b1;
               res.ends_after   = 1'b1;
               res.closed_class = MODE_TEXT;
               res.open_class   = MODE_IDLE;
            end else begin
               res.append = 1'b1;
            end
         end
         MODE_REMARK: begin
            res.open_class = MODE_REMARK;
            if (escape) begin
               res.escape = 1'b0;
            end else if (flags.is_bslash) begin
               res.escape = 1'b1;
            end else if (flags.is_nl) begin
               res.open_class = MODE_IDLE;
            end
         end
         MODE_WORD, MODE_OPER, MODE_SEPA, MODE_BRKT: begin
            unique case (mode)
               MODE_WORD: member = flags.is_word;
               MODE_OPER: member = flags.is_oper;
               MODE_SEPA: member = flags.is_sepa;
               default:   member = flags.is_brkt;
            endcase
            if (member) begin
               res.append     = 1'b1;
               res.open_class = mode;
            end else begin
               res.ends_before  = 1'b1;
               res.closed_class = mode;
               rescan           = 1'b1;
            end
         end
         default: rescan = 1'b1;
      endcase

      if (rescan) begin
         if (flags.is_space) begin
            res.open_class = MODE_IDLE;
         end else if (flags.is_hash) begin
            res.open_class = MODE_REMARK;
         end else if (flags.is_quote) begin
            res.open_class = MODE_TEXT;
            res.append     = 1'b1;
         end else if (flags.is_word) begin
            res.open_class = MODE_WORD;
            res.append     = 1'b1;
         end else if (flags.is_oper) begin
            res.open_class = MODE_OPER;
            res.append     = 1'b1;
         end else if (flags.is_sepa) begin
            res.open_class = MODE_SEPA;
            res.append     = 1'b1;
         end else if (flags.is_brkt) begin
            res.open_class = MODE_BRKT;
            res.append     = 1'b1;
         end else begin
            res.open_class = MODE_IDLE;
            res.bad_char   = 1'b1;
         end
      end
   end

endmodule

// ----- sv/char_class_tokenizer_unit.sv -----
// ----------------------------------------------------------------------------
// char_class_tokenizer_unit
// Marks token boundaries of a small lexer, one source byte per request.
// ----------------------------------------------------------------------------
// One request enters per clock cycle while the result side does not stall:
// the byte is captured in an input register, classified and run through the
// mode update combinationally, and the marks land in a result register.
// The mode and escape registers close a feedback loop, so the sustained
// rate is one byte per cycle whenever the result side does not stall.
module char_class_tokenizer_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_ch,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_out_char,
   output logic                rsp_append,
   output logic                rsp_ends_before,
   output logic                rsp_ends_after,
   output logic [2:0]          rsp_closed_class,
   output logic [2:0]          rsp_open_class,
   output logic                rsp_bad_char
);
   import cct_pkg::*;

   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_ch_ff, in_ch_in;
   logic            out_valid_ff, out_valid_in;
   logic [7:0]      out_char_ff, out_char_in;
   step_result_type out_res_ff, out_res_in;
   mode_type        mode_ff, mode_in;
   logic            escape_ff, escape_in;

   logic            accept;
   logic            advance;
   char_class_type  flags;
   step_result_type res;

   cct_classify u_classify (
      .ch    (in_ch_ff),
      .flags (flags)
   );

   cct_step u_step (
      .mode   (mode_ff),
      .escape (escape_ff),
      .flags  (flags),
      .res    (res)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      in_ch_in     = accept ? req_ch : in_ch_ff;
      out_valid_in = advance ? 1'b1 : ((out_valid_ff && !rsp_stall) ? 1'b0 : out_valid_ff);
      out_char_in  = advance ? in_ch_ff : out_char_ff;
      out_res_in   = advance ? res : out_res_ff;
      mode_in      = advance ? res.open_class : mode_ff;
      escape_in    = advance ? res.escape : escape_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff      <= MODE_IDLE;
         escape_ff    <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         mode_ff      <= mode_in;
         escape_ff    <= escape_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ch_ff    <= in_ch_in;
      out_char_ff <= out_char_in;
      out_res_ff  <= out_res_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_out_char     = out_char_ff;
   assign rsp_append       = out_res_ff.append;
   assign rsp_ends_before  = out_res_ff.ends_before;
   assign rsp_ends_after   = out_res_ff.ends_after;
   assign rsp_closed_class = out_res_ff.closed_class;
   assign rsp_open_class   = out_res_ff.open_class;
   assign rsp_bad_char     = out_res_ff.bad_char;

   // escape only pending inside text or a remark
   assert property (@(posedge clock) disable iff (reset)
      escape_ff |-> (mode_ff == MODE_TEXT) || (mode_ff == MODE_REMARK))
      else $error("escape pending outside text or remark");

   // the mode register tracks the open class of the last result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (mode_ff == mode_type'(rsp_open_class)))
      else $error("mode differs from last open class");

   // a closing quote reports a finished text token
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ends_after) |->
         (rsp_append && (rsp_closed_class == MODE_TEXT) && !rsp_ends_before))
      else $error("malformed text close");

   // a dropped byte returns to idle and is never appended
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_char) |-> (!rsp_append && (rsp_open_class == MODE_IDLE)))
      else $error("bad byte appended or mode left open");

   // a stall toward the requester only while a request is held
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff))
      else $error("stall without held request");

endmodule
